FILE: sv/ida_pkg.sv
`timescale 1ns / 1ps
package ida_pkg;
    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int SQ_W       = 49;
    localparam int SUM_W      = 50;
    localparam int ROOT_W     = 25;
    localparam int REM_W      = 26;
    localparam int GAIN_W     = 16;
    localparam int QUOT_W     = 15;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LISTENER_Z = 2'd2;

    localparam logic [COORD_W-1:0] DIST_MAX = {COORD_W{1'b1}};
    localparam logic [GAIN_W-1:0]  GAIN_ONE = 16'h8000;

    // one request between front and back
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COORD_W-1:0] ref_d;
        logic [COORD_W-1:0] max_d;
    } t_item;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_FULL = 2'd1,
        KIND_DIV  = 2'd2
    } t_kind;
endpackage

FILE: sv/ida_front.sv
`timescale 1ns / 1ps
module ida_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ida_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ida_pkg::COORD_W-1:0]   i_cfg_data,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [ida_pkg::COORD_W-1:0]   i_src_x,
    input  logic [ida_pkg::COORD_W-1:0]   i_src_y,
    input  logic [ida_pkg::COORD_W-1:0]   i_src_z,
    input  logic [ida_pkg::COORD_W-1:0]   i_ref_distance,
    input  logic [ida_pkg::COORD_W-1:0]   i_max_distance,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output ida_pkg::t_item                o_q_item
);
    import ida_pkg::*;

    logic [COORD_W-1:0] r_lx, r_ly, r_lz;
    logic               r_v1, r_v2, r_v3;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]    r_sx, r_sy, r_sz;
    logic [COORD_W-1:0] r_ref1, r_max1, r_ref2, r_max2, r_ref3, r_max3;
    logic [SUM_W-1:0]   r_sum;
    logic               w_en;
    logic [DIFF_W-1:0]  w_ax, w_ay, w_az;

    // hold the whole front while the last stage cannot leave
    assign w_en     = !(r_v3 && i_q_full);
    assign o_full   = !w_en;
    assign o_q_push = r_v3 && w_en;
    assign o_q_item = '{sum: r_sum, ref_d: r_ref3, max_d: r_max3};

    // listener registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx <= '0;
            r_ly <= '0;
            r_lz <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LISTENER_X: r_lx <= i_cfg_data;
                REG_LISTENER_Y: r_ly <= i_cfg_data;
                REG_LISTENER_Z: r_lz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // magnitudes of the differences
    assign w_ax = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
    assign w_ay = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
    assign w_az = r_dz[DIFF_W-1] ? DIFF_W'(-r_dz) : DIFF_W'(r_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // advance the datapath: difference, square, sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx   <= $signed({i_src_x[COORD_W-1], i_src_x}) - $signed({r_lx[COORD_W-1], r_lx});
            r_dy   <= $signed({i_src_y[COORD_W-1], i_src_y}) - $signed({r_ly[COORD_W-1], r_ly});
            r_dz   <= $signed({i_src_z[COORD_W-1], i_src_z}) - $signed({r_lz[COORD_W-1], r_lz});
            r_ref1 <= i_ref_distance;
            r_max1 <= i_max_distance;
            r_sx   <= SQ_W'(w_ax[DIFF_W-2:0] * w_ax[DIFF_W-2:0]) | (w_ax[DIFF_W-1] ? SQ_W'(1) << (SQ_W-1) : '0);
            r_sy   <= SQ_W'(w_ay[DIFF_W-2:0] * w_ay[DIFF_W-2:0]) | (w_ay[DIFF_W-1] ? SQ_W'(1) << (SQ_W-1) : '0);
            r_sz   <= SQ_W'(w_az[DIFF_W-2:0] * w_az[DIFF_W-2:0]) | (w_az[DIFF_W-1] ? SQ_W'(1) << (SQ_W-1) : '0);
            r_ref2 <= r_ref1;
            r_max2 <= r_max1;
            r_sum  <= SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
            r_ref3 <= r_ref2;
            r_max3 <= r_max2;
        end
    end
endmodule

FILE: sv/ida_queue.sv
`timescale 1ns / 1ps
module ida_queue #(
    parameter int Depth = ida_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ida_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ida_pkg::t_item o_item
);
    import ida_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_item            r_mem [0:Depth-1];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [CntW-1:0]  r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CntW'(Depth));
    assign o_empty   = (r_cnt == '0);
    assign o_item    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // store the incoming request
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(w_do_push) - CntW'(w_do_pop);
        end
    end
endmodule

FILE: sv/ida_back.sv
`timescale 1ns / 1ps
module ida_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  ida_pkg::t_item             i_q_item,
    output logic                       o_q_pop,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [ida_pkg::GAIN_W-1:0] o_gain
);
    import ida_pkg::*;

    localparam int SQ = SQRT_STEPS;
    localparam int DV = DIV_STEPS;

    logic               w_en;
    // square-root stages
    logic               r_sv   [0:SQ];
    logic [SUM_W-1:0]   r_sn   [0:SQ];
    logic [REM_W-1:0]   r_srem [0:SQ];
    logic [ROOT_W-1:0]  r_sroot[0:SQ];
    logic [COORD_W-1:0] r_sref [0:SQ];
    logic [COORD_W-1:0] r_smax [0:SQ];
    logic [REM_W+1:0]   w_sh   [0:SQ-1];
    logic [REM_W+1:0]   w_trial[0:SQ-1];
    logic               w_stake[0:SQ-1];
    // division stages
    logic               r_dv   [0:DV];
    t_kind              r_dk   [0:DV];
    logic [COORD_W:0]   r_drem [0:DV];
    logic [COORD_W-1:0] r_dd   [0:DV];
    logic [QUOT_W-1:0]  r_dq   [0:DV];
    logic [COORD_W+1:0] w_dsh  [0:DV-1];
    logic               w_dtake[0:DV-1];
    logic [COORD_W-1:0] w_dist;
    t_kind              w_kind;
    logic               r_out_v;
    logic [GAIN_W-1:0]  r_gain;
    logic [GAIN_W-1:0]  w_gain;

    // the whole back moves when the output register frees
    assign w_en    = !r_out_v || i_pop;
    assign o_q_pop = w_en && !i_q_empty;
    assign o_empty = !r_out_v;
    assign o_gain  = r_gain;

    // one root bit per stage
    always_comb begin
        for (int k = 0; k < SQ; k++) begin
            w_sh[k]    = {r_srem[k], r_sn[k][SUM_W-1 -: 2]};
            w_trial[k] = {1'b0, r_sroot[k], 2'b01};
            w_stake[k] = (w_sh[k] >= w_trial[k]);
        end
    end

    // saturate the distance and classify
    assign w_dist = r_sroot[SQ][ROOT_W-1] ? DIST_MAX : r_sroot[SQ][COORD_W-1:0];
    always_comb begin
        priority if (w_dist >= r_smax[SQ]) w_kind = KIND_ZERO;
        else if (w_dist <= r_sref[SQ])     w_kind = KIND_FULL;
        else                               w_kind = KIND_DIV;
    end

    // one quotient bit per stage
    always_comb begin
        for (int j = 0; j < DV; j++) begin
            w_dsh[j]   = {r_drem[j], 1'b0};
            w_dtake[j] = (w_dsh[j] >= {2'b00, r_dd[j]});
        end
    end

    always_comb begin
        unique case (r_dk[DV])
            KIND_ZERO: w_gain = '0;
            KIND_FULL: w_gain = GAIN_ONE;
            KIND_DIV:  w_gain = {1'b0, r_dq[DV]};
            default:   w_gain = '0;
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQ; k++) r_sv[k] <= 1'b0;
            for (int j = 0; j <= DV; j++) r_dv[j] <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_sv[0] <= !i_q_empty;
            for (int k = 0; k < SQ; k++) r_sv[k+1] <= r_sv[k];
            r_dv[0] <= r_sv[SQ];
            for (int j = 0; j < DV; j++) r_dv[j+1] <= r_dv[j];
            r_out_v <= r_dv[DV];
        end
    end

    // advance the datapath
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sn[0]    <= i_q_item.sum;
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            r_sref[0]  <= i_q_item.ref_d;
            r_smax[0]  <= i_q_item.max_d;
            for (int k = 0; k < SQ; k++) begin
                r_sn[k+1]    <= {r_sn[k][SUM_W-3:0], 2'b00};
                r_srem[k+1]  <= w_stake[k] ? REM_W'(w_sh[k] - w_trial[k]) : REM_W'(w_sh[k]);
                r_sroot[k+1] <= {r_sroot[k][ROOT_W-2:0], w_stake[k]};
                r_sref[k+1]  <= r_sref[k];
                r_smax[k+1]  <= r_smax[k];
            end
            r_dk[0]   <= w_kind;
            r_drem[0] <= {1'b0, r_sref[SQ]};
            r_dd[0]   <= w_dist;
            r_dq[0]   <= '0;
            for (int j = 0; j < DV; j++) begin
                r_dk[j+1]   <= r_dk[j];
                r_drem[j+1] <= w_dtake[j] ? (COORD_W+1)'(w_dsh[j] - {2'b00, r_dd[j]})
                                          : (COORD_W+1)'(w_dsh[j]);
                r_dd[j+1]   <= r_dd[j];
                r_dq[j+1]   <= {r_dq[j][QUOT_W-2:0], w_dtake[j]};
            end
            r_gain <= w_gain;
        end
    end
endmodule

FILE: sv/inverse_distance_attenuation_top.sv
`timescale 1ns / 1ps
// Channel   Ports                                  Request moves when
// config    i_cfg_we, i_cfg_idx, i_cfg_data        i_cfg_we high
// input     i_push/o_full, i_src_*, i_*_distance   i_push high and o_full low
// result    o_empty/i_pop, o_gain                  i_pop high and o_empty low
//
// One request per cycle sustained while o_full stays low. A request runs through 3 front
// stages, the queue, 26 square-root registers, 16 divide registers and the output
// register before o_empty falls. Reset (i_rst_n low, synchronous) clears the
// listener to zero and empties every stage. A held result stalls the back pipeline;
// the front keeps filling the queue and raises o_full once the queue is full and
// its last stage holds a request.
module inverse_distance_attenuation_top #(
    parameter int QueueDepth = ida_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ida_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ida_pkg::COORD_W-1:0]   i_cfg_data,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [ida_pkg::COORD_W-1:0]   i_src_x,
    input  logic [ida_pkg::COORD_W-1:0]   i_src_y,
    input  logic [ida_pkg::COORD_W-1:0]   i_src_z,
    input  logic [ida_pkg::COORD_W-1:0]   i_ref_distance,
    input  logic [ida_pkg::COORD_W-1:0]   i_max_distance,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [ida_pkg::GAIN_W-1:0]    o_gain
);
    import ida_pkg::*;

    logic  w_q_push, w_q_full, w_q_pop, w_q_empty;
    t_item w_q_in, w_q_out;

    ida_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_push, .o_full, .i_src_x, .i_src_y, .i_src_z,
        .i_ref_distance, .i_max_distance,
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_item (w_q_in)
    );

    ida_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk, .i_rst_n,
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_q_out)
    );

    ida_back u_back (
        .i_clk, .i_rst_n,
        .i_q_empty (w_q_empty),
        .i_q_item  (w_q_out),
        .o_q_pop   (w_q_pop),
        .o_empty, .i_pop, .o_gain
    );
endmodule
